[design/gwp_pkg.sv]
// gwp_pkg: shared types and constants of the g-code word parser
// holds the word record passed from front to back, character codes and mode codes
// depends on nothing
`timescale 1ns / 1ps

package gwp_pkg;

	// depth of the word queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_Y     = 8'h59;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_J     = 8'h4A;

	// motion modes
	localparam logic [2:0] MODE_RAPID  = 3'd0;
	localparam logic [2:0] MODE_LINEAR = 3'd1;
	localparam logic [2:0] MODE_CW     = 3'd2;
	localparam logic [2:0] MODE_CCW    = 3'd3;
	localparam logic [2:0] MODE_HOME   = 3'd4;

	// g and m code numbers
	localparam longint CODE_G_HOME  = 75;
	localparam longint CODE_G_CLEAR = 30;
	localparam longint CODE_M_ON    = 3;
	localparam longint CODE_M_OFF   = 5;

	// control part of one word record
	typedef struct packed {
		logic       eol;       // this record closes the line
		logic       has_word;  // a word is to be finished
		logic [7:0] letter;
		logic [2:0] frac;      // fraction digits taken
		logic       neg;
		logic       digit;     // at least one digit seen
	} word_ctrl_t;

	localparam int WORD_CTRL_BITS = $bits(word_ctrl_t);

	// powers of ten for fraction scaling, up to six digits
	function automatic logic [19:0] pow10(input logic [2:0] k);
		logic [19:0] r;
		unique case (k)
			3'd0: r = 20'd1;
			3'd1: r = 20'd10;
			3'd2: r = 20'd100;
			3'd3: r = 20'd1000;
			3'd4: r = 20'd10000;
			3'd5: r = 20'd100000;
			3'd6: r = 20'd1000000;
			default: r = 20'd1;
		endcase
		return r;
	endfunction

endpackage

[design/gwp_queue.sv]
// gwp_queue: short fifo of word records between the front and the back
// uses gwp_pkg for the queue depth
`timescale 1ns / 1ps

module gwp_queue #(
	parameter int WIDTH = 47
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);
	import gwp_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CW'(QUEUE_DEPTH)))
		else $error("word pushed into full queue");
	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("word popped from empty queue");
`endif

endmodule

[design/gwp_front.sv]
// gwp_front: character scanner, builds one word record per finished word or line end
// uses gwp_pkg for character codes and the word record type
`timescale 1ns / 1ps

module gwp_front #(
	parameter int FRAC_DIGITS = 3,
	parameter int VALUE_BITS  = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [7:0]              char_in,
	output logic                    push,
	output gwp_pkg::word_ctrl_t     push_ctrl,
	output logic [VALUE_BITS-1:0]   push_mag
);
	import gwp_pkg::*;

	localparam int VB = VALUE_BITS;
	localparam logic [VB+3:0] CAP = (VB+4)'(1) << (VB - 1);

	typedef enum logic [1:0] {
		PH_LETTER = 2'b01,
		PH_NUMBER = 2'b10
	} phase_t;

	phase_t        phase_q, phase_d;
	logic [7:0]    letter_q, letter_d;
	logic [VB-1:0] accum_q, accum_d;
	logic [2:0]    frac_q, frac_d;
	logic          neg_q, neg_d;
	logic          plus_q, plus_d;
	logic          point_q, point_d;
	logic          digit_q, digit_d;

	logic          fire;
	logic          is_digit;
	logic [VB+3:0] mad;
	logic [VB-1:0] mad_sat;
	logic          sign_ok;

	assign fire     = in_valid & in_ready;
	assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	// times ten plus digit, saturated at the magnitude cap
	assign mad      = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1)
	                + (VB+4)'(char_in - CH_ZERO);
	assign mad_sat  = (mad > CAP) ? CAP[VB-1:0] : mad[VB-1:0];
	assign sign_ok  = !neg_q && !plus_q && !point_q && !digit_q;

	assign push_ctrl.eol      = (char_in == CH_NUL);
	assign push_ctrl.has_word = (phase_q == PH_NUMBER);
	assign push_ctrl.letter   = letter_q;
	assign push_ctrl.frac     = frac_q;
	assign push_ctrl.neg      = neg_q;
	assign push_ctrl.digit    = digit_q;
	assign push_mag           = accum_q;

	always_comb begin
		phase_d  = phase_q;
		letter_d = letter_q;
		accum_d  = accum_q;
		frac_d   = frac_q;
		neg_d    = neg_q;
		plus_d   = plus_q;
		point_d  = point_q;
		digit_d  = digit_q;
		push     = 1'b0;
		if (fire) begin
			priority if (char_in == CH_NUL) begin
				push     = 1'b1;
				phase_d  = PH_LETTER;
				letter_d = CH_NUL;
				accum_d  = '0;
				frac_d   = '0;
				neg_d    = 1'b0;
				plus_d   = 1'b0;
				point_d  = 1'b0;
				digit_d  = 1'b0;
			end else if (phase_q == PH_NUMBER && is_digit) begin
				if (!point_q) begin
					accum_d = mad_sat;
				end else if (frac_q < 3'(FRAC_DIGITS)) begin
					accum_d = mad_sat;
					frac_d  = frac_q + 1'b1;
				end
				digit_d = 1'b1;
			end else if (phase_q == PH_NUMBER && sign_ok
			             && (char_in == CH_MINUS || char_in == CH_PLUS)) begin
				neg_d  = (char_in == CH_MINUS);
				plus_d = (char_in == CH_PLUS);
			end else if (phase_q == PH_NUMBER && char_in == CH_POINT && !point_q) begin
				point_d = 1'b1;
			end else begin
				// any other character ends a pending word and opens the next one
				push     = (phase_q == PH_NUMBER);
				phase_d  = PH_NUMBER;
				letter_d = char_in;
				accum_d  = '0;
				frac_d   = '0;
				neg_d    = 1'b0;
				plus_d   = 1'b0;
				point_d  = 1'b0;
				digit_d  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LETTER;
			letter_q <= CH_NUL;
			accum_q  <= '0;
			frac_q   <= '0;
			neg_q    <= 1'b0;
			plus_q   <= 1'b0;
			point_q  <= 1'b0;
			digit_q  <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			letter_q <= letter_d;
			accum_q  <= accum_d;
			frac_q   <= frac_d;
			neg_q    <= neg_d;
			plus_q   <= plus_d;
			point_q  <= point_d;
			digit_q  <= digit_d;
		end
	end

endmodule

[design/gwp_back.sv]
// gwp_back: word executor, scales and signs numbers, updates machine state, emits line results
// uses gwp_pkg for the word record, letter codes, mode codes and powers of ten
`timescale 1ns / 1ps

module gwp_back #(
	parameter int FRAC_DIGITS = 3,
	parameter int VALUE_BITS  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  gwp_pkg::word_ctrl_t   q_ctrl,
	input  logic [VALUE_BITS-1:0] q_mag,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            motion_mode,
	output logic                  laser_on,
	output logic [31:0]           target_x,
	output logic [31:0]           target_y,
	output logic [31:0]           center_i,
	output logic [31:0]           center_j,
	output logic                  start_move,
	output logic                  clear_position
);
	import gwp_pkg::*;

	localparam int     VB    = VALUE_BITS;
	localparam int     PB    = VB + 20;
	localparam longint P     = longint'(pow10(3'(FRAC_DIGITS)));
	localparam logic [PB-1:0] CAP_W = PB'(1) << (VB - 1);
	localparam logic [VB-1:0] CAP   = VB'(1) << (VB - 1);

	// stage 1 registers
	logic                 s1_valid_q;
	word_ctrl_t           ctrl_s1;
	logic signed [VB-1:0] val_s1;
	// stage 2 registers
	logic                 s2_valid_q;
	word_ctrl_t           ctrl_s2;
	logic signed [VB-1:0] val_s2;

	// machine state
	logic [2:0]           mode_q, mode_d;
	logic                 laser_q, laser_d;
	logic signed [VB-1:0] x_q, x_d, y_q, y_d, i_q, i_d, j_q, j_d;
	logic signed [VB-1:0] last_q;
	logic                 cleared_q, cleared_d;

	// output register
	logic                 out_valid_q;
	logic [2:0]           mode_out_q;
	logic                 laser_out_q;
	logic [31:0]          x_out_q;
	logic [31:0]          y_out_q;
	logic [31:0]          i_out_q;
	logic [31:0]          j_out_q;
	logic                 start_out_q;
	logic                 clear_out_q;

	logic                 s2_ok, s2_adv, s1_adv, s2_fire;
	logic [PB-1:0]        prod;
	logic [VB-1:0]        mag;
	logic signed [VB-1:0] val_d;
	logic signed [VB-1:0] v;
	logic signed [63:0]   vx;
	logic                 in_g0_3, is_g75, is_g30, is_m3, is_m5;

	assign s2_ok   = !ctrl_s2.eol || !out_valid_q || out_ready;
	assign s2_adv  = !s2_valid_q || s2_ok;
	assign s1_adv  = !s1_valid_q || s2_adv;
	assign q_pop   = !q_empty && s1_adv;
	assign s2_fire = s2_valid_q && s2_ok;

	// stage 1: pad missing fraction digits, saturate, apply sign
	assign prod = PB'(q_mag) * PB'(pow10(3'(FRAC_DIGITS) - q_ctrl.frac));
	assign mag  = (prod > CAP_W) ? CAP : prod[VB-1:0];
	always_comb begin
		if (q_ctrl.neg) begin
			val_d = -$signed(mag);
		end else if (mag > CAP - 1'b1) begin
			val_d = $signed(CAP - 1'b1);
		end else begin
			val_d = $signed(mag);
		end
	end

	// stage 2: word value falls back to the last number read in this line
	assign v  = ctrl_s2.digit ? val_s2 : last_q;
	assign vx = 64'(v);

	// code number is the integer part truncated toward zero, tested by ranges
	assign in_g0_3 = (vx > -P) && (vx < 4 * P);
	assign is_g75  = (vx >= CODE_G_HOME * P) && (vx < (CODE_G_HOME + 1) * P);
	assign is_g30  = (vx >= CODE_G_CLEAR * P) && (vx < (CODE_G_CLEAR + 1) * P);
	assign is_m3   = (vx >= CODE_M_ON * P) && (vx < (CODE_M_ON + 1) * P);
	assign is_m5   = (vx >= CODE_M_OFF * P) && (vx < (CODE_M_OFF + 1) * P);

	always_comb begin
		mode_d    = mode_q;
		laser_d   = laser_q;
		x_d       = x_q;
		y_d       = y_q;
		i_d       = i_q;
		j_d       = j_q;
		cleared_d = cleared_q;
		if (ctrl_s2.has_word) begin
			unique case (ctrl_s2.letter)
				CH_G: begin
					// unknown g codes leave the state alone
					if (in_g0_3) begin
						priority if (vx >= 3 * P) mode_d = MODE_CCW;
						else if (vx >= 2 * P)     mode_d = MODE_CW;
						else if (vx >= P)         mode_d = MODE_LINEAR;
						else                      mode_d = MODE_RAPID;
					end else if (is_g75) begin
						mode_d = MODE_HOME;
						x_d    = '0;
						y_d    = '0;
					end else if (is_g30) begin
						x_d       = '0;
						y_d       = '0;
						cleared_d = 1'b1;
					end
				end
				CH_M: begin
					if (is_m3)      laser_d = 1'b1;
					else if (is_m5) laser_d = 1'b0;
				end
				CH_X: x_d = v;
				CH_Y: y_d = v;
				CH_I: i_d = v;
				CH_J: j_d = v;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			mode_q      <= MODE_RAPID;
			laser_q     <= 1'b0;
			x_q         <= '0;
			y_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			last_q      <= '0;
			cleared_q   <= 1'b0;
		end else begin
			if (s1_adv) begin
				s1_valid_q <= q_pop;
			end
			if (s2_adv) begin
				s2_valid_q <= s1_valid_q;
			end
			if (s2_fire) begin
				mode_q  <= mode_d;
				laser_q <= laser_d;
				x_q     <= x_d;
				y_q     <= y_d;
				i_q     <= i_d;
				j_q     <= j_d;
				if (ctrl_s2.eol) begin
					last_q    <= '0;
					cleared_q <= 1'b0;
				end else begin
					if (ctrl_s2.has_word) begin
						last_q <= v;
					end
					cleared_q <= cleared_d;
				end
			end
			if (s2_fire && ctrl_s2.eol) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ctrl_s1 <= q_ctrl;
			val_s1  <= val_d;
		end
		if (s2_adv && s1_valid_q) begin
			ctrl_s2 <= ctrl_s1;
			val_s2  <= val_s1;
		end
		if (s2_fire && ctrl_s2.eol) begin
			mode_out_q  <= mode_d;
			laser_out_q <= laser_d;
			x_out_q     <= 32'(64'(x_d));
			y_out_q     <= 32'(64'(y_d));
			i_out_q     <= 32'(64'(i_d));
			j_out_q     <= 32'(64'(j_d));
			start_out_q <= (mode_d <= MODE_LINEAR);
			clear_out_q <= cleared_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign motion_mode    = mode_out_q;
	assign laser_on       = laser_out_q;
	assign target_x       = x_out_q;
	assign target_y       = y_out_q;
	assign center_i       = i_out_q;
	assign center_j       = j_out_q;
	assign start_move     = start_out_q;
	assign clear_position = clear_out_q;

`ifndef NO_ASSERTIONS
	a_result_from_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s2_fire && ctrl_s2.eol))
		else $error("result appeared without a line end");
	a_start_move_matches_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (start_move == (motion_mode <= MODE_LINEAR)))
		else $error("start flag disagrees with motion mode");
`endif

endmodule

[design/gcode_word_parser.sv]
// gcode_word_parser: top level of the g-code word parser
// instantiates gwp_front, gwp_queue and gwp_back; uses gwp_pkg
// path: the record of the zero byte goes through the word queue, stage 1, stage 2 and the result register
// throughput: one character per cycle; the front takes characters while the queue has room,
// the back retires one word record per cycle, held only by an unread result
// reset: arst_n clears mode, laser, targets, centres and the scanner at once
`timescale 1ns / 1ps

module gcode_word_parser #(
	parameter int FRAC_DIGITS = 3,  // fraction digits kept, 0 to 6
	parameter int VALUE_BITS  = 32  // signed number range, 16 to 48
) (
	input  logic         clk,
	input  logic         arst_n,
	// character stream in
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // char_in
	// line result out
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata    // motion_mode[2:0], laser_on, target_x, target_y,
	                                // center_i, center_j, start_move, clear_position, pad
);
	import gwp_pkg::*;

	localparam int QW = WORD_CTRL_BITS + VALUE_BITS;

	// front to queue
	logic                  push;
	word_ctrl_t            push_ctrl;
	logic [VALUE_BITS-1:0] push_mag;
	// queue to back
	logic                  q_full;
	logic                  q_empty;
	logic                  q_pop;
	logic [QW-1:0]         q_data;
	word_ctrl_t            q_ctrl;
	logic [VALUE_BITS-1:0] q_mag;

	// result fields
	logic [2:0]  motion_mode;
	logic        laser_on;
	logic [31:0] target_x;
	logic [31:0] target_y;
	logic [31:0] center_i;
	logic [31:0] center_j;
	logic        start_move;
	logic        clear_position;

	// a character is taken whenever the word queue has a free slot
	assign s_tready = !q_full;

	gwp_front #(
		.FRAC_DIGITS(FRAC_DIGITS),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.char_in  (s_tdata),
		.push     (push),
		.push_ctrl(push_ctrl),
		.push_mag (push_mag)
	);

	// word records queue up so the scanner waits on a stalled result only once the queue is full
	gwp_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_ctrl, push_mag}),
		.pop      (q_pop),
		.pop_data (q_data),
		.full     (q_full),
		.empty    (q_empty)
	);

	assign q_ctrl = q_data[QW-1:VALUE_BITS];
	assign q_mag  = q_data[VALUE_BITS-1:0];

	// back end: two stages plus the result register
	gwp_back #(
		.FRAC_DIGITS(FRAC_DIGITS),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_ctrl        (q_ctrl),
		.q_mag         (q_mag),
		.q_pop         (q_pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.motion_mode   (motion_mode),
		.laser_on      (laser_on),
		.target_x      (target_x),
		.target_y      (target_y),
		.center_i      (center_i),
		.center_j      (center_j),
		.start_move    (start_move),
		.clear_position(clear_position)
	);

	// pack the result item, first field in the low bits, two pad bits on top
	assign m_tdata = {2'b00, clear_position, start_move, center_j, center_i,
	                  target_y, target_x, laser_on, motion_mode};

endmodule
